// ----- rtl/stroke_dab_spacer_dirty_rect_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stroke dab spacer
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STROKE_DAB_SPACER_DIRTY_RECT_ASSERT_SVH
`define STROKE_DAB_SPACER_DIRTY_RECT_ASSERT_SVH
`ifndef SYNTH
`define SDSDR_ASSERT_IMPLY(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SDSDR_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SDSDR_ASSERT_IMPLY(lbl, clk, rst_n, a, c, msg)
`define SDSDR_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// ----- rtl/sdsdr_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsdr_pkg
// Shared codes, constants and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none
package sdsdr_pkg;

    localparam int DEF_PENDING_CAPACITY = 64;
    localparam int DEF_TILE_SIZE        = 32;

    localparam logic [2:0] OP_SAMPLE = 3'd0;
    localparam logic [2:0] OP_BEGIN  = 3'd1;
    localparam logic [2:0] OP_END    = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_RESET  = 3'd4;

    localparam logic [19:0] RADIUS_RESET = 20'd4096;
    localparam logic [19:0] MIN_SPACING  = 20'd1024;

    localparam logic [4:0] SQ_STEPS  = 5'd27;
    localparam logic [4:0] DIV_STEPS = 5'd26;

    typedef struct packed {
        logic take;
        logic square;
        logic sq_load;
        logic sq_step;
        logic seg_start;
        logic mul;
        logic div_load;
        logic div_step;
        logic pos;
        logic rect_a;
        logic rect_b;
        logic rect_c;
        logic t_step;
    } sdsdr_cmd_t;

    typedef struct packed {
        logic first_dab;
        logic seg_dab;
        logic short_move;
        logic more;
        logic last;
    } sdsdr_status_t;

    typedef struct packed {
        logic [23:0] dab_x;
        logic [23:0] dab_y;
        logic [16:0] dab_pressure;
        logic [15:0] dirty_x;
        logic [15:0] dirty_y;
        logic [16:0] dirty_w;
        logic [16:0] dirty_h;
        logic [6:0]  pending_count;
        logic        last;
    } sdsdr_result_t;

endpackage
`default_nettype wire

// ----- rtl/sdsdr_if.sv -----
// ----------------------------------------------------------------------------
// sdsdr channel interfaces
// Valid/ready channels for pen samples in and dab words out.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdsdr_smp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [17:0] pressure;
    modport source (output valid, op, pos_x, pos_y, pressure, input ready);
    modport sink (input valid, op, pos_x, pos_y, pressure, output ready);
endinterface

interface sdsdr_dab_if;
    logic        valid;
    logic        ready;
    logic [23:0] dab_x;
    logic [23:0] dab_y;
    logic [16:0] dab_pressure;
    logic [15:0] dirty_x;
    logic [15:0] dirty_y;
    logic [16:0] dirty_w;
    logic [16:0] dirty_h;
    logic [6:0]  pending_count;
    logic        last;
    modport source (output valid, dab_x, dab_y, dab_pressure, dirty_x, dirty_y, dirty_w,
                    dirty_h, pending_count, last, input ready);
    modport sink (input valid, dab_x, dab_y, dab_pressure, dirty_x, dirty_y, dirty_w,
                  dirty_h, pending_count, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/sdsdr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdsdr_ctrl
// Sequencer: square, root, per-dab divide, rectangle stages, output word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stroke_dab_spacer_dirty_rect_assert.svh"
module sdsdr_ctrl import sdsdr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_acc,
    input  wire logic          out_acc,
    input  wire sdsdr_status_t status,
    output logic               in_ready,
    output logic               out_valid,
    output sdsdr_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQR  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_LOOP = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIVL = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_POS  = 4'd9;
    localparam logic [3:0] S_RA   = 4'd10;
    localparam logic [3:0] S_RB   = 4'd11;
    localparam logic [3:0] S_RC   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd.take = 1'b1;
                    if (status.first_dab)
                        state_next = S_RA;
                    else if (status.seg_dab)
                        state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sq_load = 1'b1;
                cnt_next    = '0;
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == SQ_STEPS - 5'd1)
                    state_next = S_CHK;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_CHK:
            begin
                if (status.short_move)
                    state_next = S_IDLE;
                else
                begin
                    cmd.seg_start = 1'b1;
                    state_next    = S_LOOP;
                end
            end
            S_LOOP:
            begin
                state_next = status.more ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVL;
            end
            S_DIVL:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_STEPS - 5'd1)
                    state_next = S_POS;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_POS:
            begin
                cmd.pos    = 1'b1;
                state_next = S_RA;
            end
            S_RA:
            begin
                cmd.rect_a = 1'b1;
                state_next = S_RB;
            end
            S_RB:
            begin
                cmd.rect_b = 1'b1;
                state_next = S_RC;
            end
            S_RC:
            begin
                cmd.rect_c = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    if (status.last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.t_step = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    `SDSDR_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready, "ready while word held")
    `SDSDR_ASSERT_IMPLY(a_sqrt_cnt, clk, rst_n, state_reg == S_SQRT, cnt_reg < SQ_STEPS, "sqrt count")
    `SDSDR_ASSERT_NEXT(a_rc_out, clk, rst_n, state_reg == S_RC, out_valid, "no word after rect")

endmodule
`default_nettype wire

// ----- rtl/sdsdr_dp.sv -----
// ----------------------------------------------------------------------------
// sdsdr_dp
// Stroke state, distance root, dab placement divide and dirty rectangle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stroke_dab_spacer_dirty_rect_assert.svh"
module sdsdr_dp import sdsdr_pkg::*;
#(
    parameter int PENDING_CAPACITY = DEF_PENDING_CAPACITY,
    parameter int TILE_SIZE        = DEF_TILE_SIZE
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sdsdr_cmd_t    cmd,
    input  wire logic [2:0]    op,
    input  wire logic [23:0]   pos_x,
    input  wire logic [23:0]   pos_y,
    input  wire logic [17:0]   pressure,
    input  wire logic [19:0]   brush_radius,
    output sdsdr_status_t      status,
    output sdsdr_result_t      res
);

    localparam int PW = $clog2(PENDING_CAPACITY + 1);
    localparam longint unsigned TILE_RECIP = (64'd1 << 30) / TILE_SIZE;

    // stroke state
    logic        active_reg, hasprev_reg;
    logic [19:0] stroke_r_reg;
    logic [23:0] prev_x_reg, prev_y_reg;
    logic [PW-1:0] pend_reg;
    logic [15:0] rminx_reg, rminy_reg;
    logic signed [17:0] rmaxx_reg, rmaxy_reg;

    // per sample / per dab work
    logic [23:0] x_reg, y_reg, base_x_reg, base_y_reg;
    logic [16:0] pr_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [49:0] sqx_reg, sqy_reg;
    logic [53:0] rad_reg;
    logic [28:0] srem_reg;
    logic [26:0] dist_reg;
    logic [27:0] t_reg;
    logic [51:0] prodx_reg, prody_reg;
    logic [26:0] drx_reg, dry_reg;
    logic [25:0] qx_reg, qy_reg;
    logic [23:0] dab_x_reg, dab_y_reg;
    logic        single_reg;
    logic [17:0] u_reg [4];
    logic [18:0] q0_reg [4];
    logic        flag_reg [4];
    logic [15:0] mnx_reg, mny_reg;
    logic signed [17:0] mxx_reg, mxy_reg;
    sdsdr_result_t res_reg;
    logic        last_reg;

    logic [19:0] spacing;
    logic        full;
    logic [16:0] pr_next;
    logic [24:0] magx, magy;

    assign spacing = (stroke_r_reg > MIN_SPACING) ? stroke_r_reg : MIN_SPACING;
    assign full    = (pend_reg >= PW'(PENDING_CAPACITY));
    assign magx    = dx_reg[24] ? 25'(-dx_reg) : 25'(dx_reg);
    assign magy    = dy_reg[24] ? 25'(-dy_reg) : 25'(dy_reg);

    always_comb
    begin
        if (pressure[17])
            pr_next = '0;
        else if ($signed(pressure) > 18'sd65536)
            pr_next = 17'd65536;
        else
            pr_next = pressure[16:0];
    end

    assign status.first_dab  = (op == OP_SAMPLE) && active_reg && !hasprev_reg && !full;
    assign status.seg_dab    = (op == OP_SAMPLE) && active_reg && hasprev_reg;
    assign status.short_move = (dist_reg < {7'd0, spacing});
    assign status.more       = ({1'b0, t_reg} <= {2'd0, dist_reg}) && !full;
    assign status.last       = last_reg;

    // root step
    logic [30:0] sq_rem2, sq_trial;
    logic        sq_ge;
    assign sq_rem2  = {srem_reg, rad_reg[53:52]};
    assign sq_trial = {2'b00, dist_reg, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);

    // divide steps, both axes
    logic [52:0] numx, numy;
    logic [27:0] dx_rem2, dy_rem2;
    logic        dx_ge, dy_ge;
    assign numx    = 53'(prodx_reg) + 53'(dist_reg >> 1);
    assign numy    = 53'(prody_reg) + 53'(dist_reg >> 1);
    assign dx_rem2 = {drx_reg, qx_reg[25]};
    assign dy_rem2 = {dry_reg, qy_reg[25]};
    assign dx_ge   = (dx_rem2 >= {1'b0, dist_reg});
    assign dy_ge   = (dy_rem2 >= {1'b0, dist_reg});

    // offsets, rounded half away from zero
    logic signed [26:0] offx, offy, posx_s, posy_s;
    assign offx   = dx_reg[24] ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign offy   = dy_reg[24] ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
    assign posx_s = $signed({{3{base_x_reg[23]}}, base_x_reg}) + offx;
    assign posy_s = $signed({{3{base_y_reg[23]}}, base_y_reg}) + offy;

    // rectangle stage A: pixel edges, reciprocal estimate of the tile index
    logic [17:0] u_a [4];
    logic        flag_a [4];
    logic [18:0] q0_a [4];
    always_comb
    begin
        logic signed [25:0] c, vlo, vhi, r26;
        logic signed [17:0] plo, phi;
        r26 = $signed({6'd0, stroke_r_reg});
        for (int i = 0; i < 2; i++)
        begin
            c   = (i == 0) ? $signed({{2{dab_x_reg[23]}}, dab_x_reg})
                           : $signed({{2{dab_y_reg[23]}}, dab_y_reg});
            vlo = c - r26;
            vhi = c + r26 + 26'sd255;
            plo = vlo[25:8];
            phi = vhi[25:8];
            u_a[2*i]      = plo;
            flag_a[2*i]   = plo[17];
            flag_a[2*i+1] = !phi[17] && (phi != 18'sd0);
            u_a[2*i+1]    = flag_a[2*i+1] ? 18'(phi + 18'(TILE_SIZE - 1)) : 18'(-phi);
        end
        for (int j = 0; j < 4; j++)
        begin
            q0_a[j] = 19'((49'(u_a[j]) * 49'(TILE_RECIP)) >> 30);
        end
    end

    // rectangle stage B: exact tile floor
    logic [17:0] tile_b [4];
    always_comb
    begin
        logic [31:0] p;
        logic [17:0] rr;
        for (int j = 0; j < 4; j++)
        begin
            p  = 32'(q0_reg[j]) * 32'(TILE_SIZE);
            rr = u_reg[j] - p[17:0];
            tile_b[j] = (rr >= 18'(TILE_SIZE)) ? p[17:0] + 18'(TILE_SIZE) : p[17:0];
        end
    end

    // rectangle stage C: union
    logic        nonempty;
    logic [15:0] nminx, nminy;
    logic signed [17:0] nmaxx, nmaxy;
    logic signed [18:0] wdiff, hdiff;
    logic [PW-1:0] pend_inc;
    logic [28:0] t_nx;
    logic        more_nx;
    assign nonempty = (rmaxx_reg > $signed({2'b00, rminx_reg}))
                   && (rmaxy_reg > $signed({2'b00, rminy_reg}));
    assign nminx = (nonempty && rminx_reg < mnx_reg) ? rminx_reg : mnx_reg;
    assign nminy = (nonempty && rminy_reg < mny_reg) ? rminy_reg : mny_reg;
    assign nmaxx = (nonempty && rmaxx_reg > mxx_reg) ? rmaxx_reg : mxx_reg;
    assign nmaxy = (nonempty && rmaxy_reg > mxy_reg) ? rmaxy_reg : mxy_reg;
    assign wdiff = $signed({nmaxx[17], nmaxx}) - $signed({3'b000, nminx});
    assign hdiff = $signed({nmaxy[17], nmaxy}) - $signed({3'b000, nminy});
    assign pend_inc = pend_reg + PW'(1);
    assign t_nx     = 29'(t_reg) + 29'(spacing);
    assign more_nx  = (t_nx <= 29'(dist_reg)) && (pend_inc < PW'(PENDING_CAPACITY));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            hasprev_reg  <= 1'b0;
            stroke_r_reg <= RADIUS_RESET;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            pend_reg     <= '0;
            rminx_reg    <= '0;
            rminy_reg    <= '0;
            rmaxx_reg    <= '0;
            rmaxy_reg    <= '0;
        end
        else if (cmd.take)
        begin
            case (op)
                OP_BEGIN:
                begin
                    stroke_r_reg <= brush_radius;
                    active_reg   <= 1'b1;
                    hasprev_reg  <= 1'b0;
                    pend_reg     <= '0;
                    rminx_reg    <= '0;
                    rminy_reg    <= '0;
                    rmaxx_reg    <= '0;
                    rmaxy_reg    <= '0;
                end
                OP_END:
                begin
                    active_reg  <= 1'b0;
                    hasprev_reg <= 1'b0;
                end
                OP_CLEAR, OP_RESET:
                begin
                    if (op == OP_RESET)
                    begin
                        active_reg  <= 1'b0;
                        hasprev_reg <= 1'b0;
                    end
                    pend_reg  <= '0;
                    rminx_reg <= '0;
                    rminy_reg <= '0;
                    rmaxx_reg <= '0;
                    rmaxy_reg <= '0;
                end
                OP_SAMPLE:
                begin
                    if (active_reg && !hasprev_reg)
                    begin
                        prev_x_reg  <= pos_x;
                        prev_y_reg  <= pos_y;
                        hasprev_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.seg_start)
        begin
            prev_x_reg <= x_reg;
            prev_y_reg <= y_reg;
        end
        else if (cmd.rect_c)
        begin
            pend_reg  <= pend_inc;
            rminx_reg <= nminx;
            rminy_reg <= nminy;
            rmaxx_reg <= nmaxx;
            rmaxy_reg <= nmaxy;
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg      <= pos_x;
            y_reg      <= pos_y;
            pr_reg     <= pr_next;
            base_x_reg <= prev_x_reg;
            base_y_reg <= prev_y_reg;
            dx_reg     <= $signed({pos_x[23], pos_x}) - $signed({prev_x_reg[23], prev_x_reg});
            dy_reg     <= $signed({pos_y[23], pos_y}) - $signed({prev_y_reg[23], prev_y_reg});
            dab_x_reg  <= pos_x;
            dab_y_reg  <= pos_y;
            single_reg <= !hasprev_reg;
        end
        if (cmd.square)
        begin
            sqx_reg <= 50'(magx) * 50'(magx);
            sqy_reg <= 50'(magy) * 50'(magy);
        end
        if (cmd.sq_load)
        begin
            rad_reg  <= {sqx_reg + sqy_reg, 4'd0};
            srem_reg <= '0;
            dist_reg <= '0;
        end
        if (cmd.sq_step)
        begin
            rad_reg  <= {rad_reg[51:0], 2'b00};
            srem_reg <= sq_ge ? 29'(sq_rem2 - sq_trial) : sq_rem2[28:0];
            dist_reg <= {dist_reg[25:0], sq_ge};
        end
        if (cmd.seg_start)
            t_reg <= 28'(spacing);
        if (cmd.t_step)
            t_reg <= t_nx[27:0];
        if (cmd.mul)
        begin
            prodx_reg <= 52'(magx) * 52'(t_reg[26:0]);
            prody_reg <= 52'(magy) * 52'(t_reg[26:0]);
        end
        if (cmd.div_load)
        begin
            drx_reg <= numx[52:26];
            dry_reg <= numy[52:26];
            qx_reg  <= numx[25:0];
            qy_reg  <= numy[25:0];
        end
        if (cmd.div_step)
        begin
            drx_reg <= dx_ge ? 27'(dx_rem2 - {1'b0, dist_reg}) : dx_rem2[26:0];
            dry_reg <= dy_ge ? 27'(dy_rem2 - {1'b0, dist_reg}) : dy_rem2[26:0];
            qx_reg  <= {qx_reg[24:0], dx_ge};
            qy_reg  <= {qy_reg[24:0], dy_ge};
        end
        if (cmd.pos)
        begin
            dab_x_reg <= posx_s[23:0];
            dab_y_reg <= posy_s[23:0];
        end
        if (cmd.rect_a)
        begin
            for (int j = 0; j < 4; j++)
            begin
                u_reg[j]    <= u_a[j];
                q0_reg[j]   <= q0_a[j];
                flag_reg[j] <= flag_a[j];
            end
        end
        if (cmd.rect_b)
        begin
            mnx_reg <= flag_reg[0] ? 16'd0 : tile_b[0][15:0];
            mny_reg <= flag_reg[2] ? 16'd0 : tile_b[2][15:0];
            mxx_reg <= flag_reg[1] ? $signed(tile_b[1]) : -$signed(tile_b[1]);
            mxy_reg <= flag_reg[3] ? $signed(tile_b[3]) : -$signed(tile_b[3]);
        end
        if (cmd.rect_c)
        begin
            res_reg.dab_x         <= dab_x_reg;
            res_reg.dab_y         <= dab_y_reg;
            res_reg.dab_pressure  <= pr_reg;
            res_reg.dirty_x       <= nminx;
            res_reg.dirty_y       <= nminy;
            res_reg.dirty_w       <= wdiff[16:0];
            res_reg.dirty_h       <= hdiff[16:0];
            res_reg.pending_count <= 7'(pend_inc);
            res_reg.last          <= single_reg || !more_nx;
            last_reg              <= single_reg || !more_nx;
        end
    end

    assign res = res_reg;

    `SDSDR_ASSERT_IMPLY(a_pend_cap, clk, rst_n, 1'b1, pend_reg <= PW'(PENDING_CAPACITY), "pending over capacity")
    `SDSDR_ASSERT_NEXT(a_emit_count, clk, rst_n, cmd.rect_c, pend_reg != '0, "emit left count zero")
    `SDSDR_ASSERT_NEXT(a_clear, clk, rst_n, cmd.take && (op == OP_CLEAR), pend_reg == '0, "clear failed")

endmodule
`default_nettype wire

// ----- rtl/stroke_dab_spacer_dirty_rect.sv -----
// Sequence: a stroke's first dab goes from accept to the rectangle stages;
// a segment runs the distance root, then per dab a multiply, a 26-step
// divide, the position and the rectangle stages, then waits on output.
// Throughput: one sample at a time; per segment, dabs up to pending capacity.
// Reset (rst_n, async, active low): no stroke, empty rectangle, radius 16 px.
// ----------------------------------------------------------------------------
// stroke_dab_spacer_dirty_rect
// Pen samples in, spaced dabs with tile-aligned dirty rectangle out.
// ----------------------------------------------------------------------------
`default_nettype none
module stroke_dab_spacer_dirty_rect import sdsdr_pkg::*;
#(
    parameter int PENDING_CAPACITY = DEF_PENDING_CAPACITY,
    parameter int TILE_SIZE        = DEF_TILE_SIZE
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sdsdr_smp_if.sink        samples,
    sdsdr_dab_if.source      dabs,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [19:0]   brush_radius_reg;
    sdsdr_cmd_t    cmd;
    sdsdr_status_t status;
    sdsdr_result_t res;
    logic          in_acc, out_acc;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            brush_radius_reg <= RADIUS_RESET;
        else if (psel && penable && pwrite && !paddr[2])
            brush_radius_reg <= pwdata[19:0];
    end

    assign prdata = paddr[2] ? 32'd0 : {12'd0, brush_radius_reg};

    assign in_acc  = samples.valid && samples.ready;
    assign out_acc = dabs.valid && dabs.ready;

    sdsdr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_acc    (in_acc),
        .out_acc   (out_acc),
        .status    (status),
        .in_ready  (samples.ready),
        .out_valid (dabs.valid),
        .cmd       (cmd)
    );

    sdsdr_dp #(
        .PENDING_CAPACITY (PENDING_CAPACITY),
        .TILE_SIZE        (TILE_SIZE)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (samples.op),
        .pos_x        (samples.pos_x),
        .pos_y        (samples.pos_y),
        .pressure     (samples.pressure),
        .brush_radius (brush_radius_reg),
        .status       (status),
        .res          (res)
    );

    assign dabs.dab_x         = res.dab_x;
    assign dabs.dab_y         = res.dab_y;
    assign dabs.dab_pressure  = res.dab_pressure;
    assign dabs.dirty_x       = res.dirty_x;
    assign dabs.dirty_y       = res.dirty_y;
    assign dabs.dirty_w       = res.dirty_w;
    assign dabs.dirty_h       = res.dirty_h;
    assign dabs.pending_count = res.pending_count;
    assign dabs.last          = res.last;

endmodule
`default_nettype wire

// ----- tb/stroke_dab_spacer_dirty_rect_test.sv -----
// ----------------------------------------------------------------------------
// stroke_dab_spacer_dirty_rect_test
// Drives pen samples and stroke ops through the dab spacer and predicts every
// dab word: spacing along each segment, clamped pressure, the tile-aligned
// dirty rectangle and the pending count. Radius is changed between phases
// over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module stroke_dab_spacer_dirty_rect_test;
    import sdsdr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PEND_CAP    = DEF_PENDING_CAPACITY;
    localparam int  TILE        = DEF_TILE_SIZE;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;

    class dab_scoreboard;
        sdsdr_result_t dab_q[$];
        int            errors;
        logic [19:0]   radius_reg;
        logic [19:0]   stroke_r;
        bit            active;
        bit            has_prev;
        longint        prev_x, prev_y;
        int            pending;
        longint        left, top, width, height;

        function new();
            errors     = 0;
            radius_reg = RADIUS_RESET;
            stroke_r   = RADIUS_RESET;
            active     = 0;
            has_prev   = 0;
            prev_x     = 0;
            prev_y     = 0;
            clear_rect();
        endfunction

        function void clear_rect();
            pending = 0;
            left    = 0;
            top     = 0;
            width   = 0;
            height  = 0;
        endfunction

        function void set_radius(logic [19:0] r);
            radius_reg = r;
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if (a % b != 0 && a < 0)
                q--;
            return q;
        endfunction

        function longint cdiv(longint a, longint b);
            longint q;
            q = a / b;
            if (a % b != 0 && a > 0)
                q++;
            return q;
        endfunction

        function longint rdiv(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint root_floor(longint v);
            longint r;
            longint t;
            r = 0;
            for (int i = 31; i >= 0; i--)
            begin
                t = r | (longint'(1) << i);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        // returns 0 when the pending list is full
        function bit place_dab(longint x, longint y, logic [16:0] pr,
                               ref sdsdr_result_t words[$]);
            longint r, x0, y0, x1, y1;
            sdsdr_result_t w;
            if (pending >= PEND_CAP)
                return 0;
            pending++;
            r  = longint'(stroke_r);
            x0 = fdiv(fdiv(x - r, 256), TILE) * TILE;
            y0 = fdiv(fdiv(y - r, 256), TILE) * TILE;
            x1 = cdiv(cdiv(x + r, 256), TILE) * TILE;
            y1 = cdiv(cdiv(y + r, 256), TILE) * TILE;
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (width > 0 && height > 0)
            begin
                if (left < x0) x0 = left;
                if (top < y0) y0 = top;
                if (left + width > x1) x1 = left + width;
                if (top + height > y1) y1 = top + height;
            end
            left   = x0;
            top    = y0;
            width  = x1 - x0;
            height = y1 - y0;
            w.dab_x         = x[23:0];
            w.dab_y         = y[23:0];
            w.dab_pressure  = pr;
            w.dirty_x       = left[15:0];
            w.dirty_y       = top[15:0];
            w.dirty_w       = width[16:0];
            w.dirty_h       = height[16:0];
            w.pending_count = pending[6:0];
            w.last          = 1'b0;
            words.push_back(w);
            return 1;
        endfunction

        function void note_sample(logic [2:0] op, logic [23:0] px, logic [23:0] py,
                                  logic [17:0] praw);
            longint x, y, p, dx, dy, spacing, seg_len, n, t;
            logic [16:0] pr;
            sdsdr_result_t words[$];
            case (op)
                OP_BEGIN:
                begin
                    stroke_r = radius_reg;
                    active   = 1;
                    has_prev = 0;
                    clear_rect();
                    return;
                end
                OP_END:
                begin
                    active   = 0;
                    has_prev = 0;
                    return;
                end
                OP_CLEAR:
                begin
                    clear_rect();
                    return;
                end
                OP_RESET:
                begin
                    clear_rect();
                    active   = 0;
                    has_prev = 0;
                    return;
                end
                default: ;
            endcase
            if (op != OP_SAMPLE || !active)
                return;
            x  = longint'($signed(px));
            y  = longint'($signed(py));
            p  = longint'($signed(praw));
            pr = (p < 0) ? 17'd0 : ((p > 65536) ? 17'd65536 : p[16:0]);
            if (!has_prev)
            begin
                void'(place_dab(x, y, pr, words));
                prev_x   = x;
                prev_y   = y;
                has_prev = 1;
            end
            else
            begin
                spacing = (stroke_r > 1024) ? longint'(stroke_r) : 1024;
                dx      = x - prev_x;
                dy      = y - prev_y;
                seg_len = root_floor((dx * dx + dy * dy) * 16);
                // short move keeps the previous point
                if (seg_len < spacing)
                    return;
                n = seg_len / spacing;
                for (longint k = 1; k <= n && words.size() < PEND_CAP; k++)
                begin
                    t = k * spacing;
                    if (!place_dab(prev_x + rdiv(dx * t, seg_len),
                                   prev_y + rdiv(dy * t, seg_len), pr, words))
                        break;
                end
                prev_x = x;
                prev_y = y;
            end
            if (words.size() > 0)
                words[words.size() - 1].last = 1'b1;
            foreach (words[i])
                dab_q.push_back(words[i]);
        endfunction

        function void check_dab(sdsdr_result_t got);
            sdsdr_result_t exp_w;
            if (dab_q.size() == 0)
            begin
                $display("%0t: unexpected dab word %p", $time, got);
                errors++;
                return;
            end
            exp_w = dab_q.pop_front();
            if (got.dab_x !== exp_w.dab_x)
                report("dab_x", exp_w.dab_x, got.dab_x);
            if (got.dab_y !== exp_w.dab_y)
                report("dab_y", exp_w.dab_y, got.dab_y);
            if (got.dab_pressure !== exp_w.dab_pressure)
                report("dab_pressure", exp_w.dab_pressure, got.dab_pressure);
            if (got.dirty_x !== exp_w.dirty_x)
                report("dirty_x", exp_w.dirty_x, got.dirty_x);
            if (got.dirty_y !== exp_w.dirty_y)
                report("dirty_y", exp_w.dirty_y, got.dirty_y);
            if (got.dirty_w !== exp_w.dirty_w)
                report("dirty_w", exp_w.dirty_w, got.dirty_w);
            if (got.dirty_h !== exp_w.dirty_h)
                report("dirty_h", exp_w.dirty_h, got.dirty_h);
            if (got.pending_count !== exp_w.pending_count)
                report("pending_count", exp_w.pending_count, got.pending_count);
            if (got.last !== exp_w.last)
                report("last", exp_w.last, got.last);
        endfunction

        function void report(string field, logic [23:0] e, logic [23:0] a);
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, e, a);
            errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sdsdr_smp_if smp();
    sdsdr_dab_if dab();

    dab_scoreboard sb;
    bit          no_idle;
    bit          hold_long;
    int          cycles;
    longint      cur_x, cur_y;

    stroke_dab_spacer_dirty_rect u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .dabs    (dab),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** stroke_dab_spacer_dirty_rect: FAILED **");
            $finish;
        end
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // dab receiver: checks accepted words, stalls at random
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dab.valid && dab.ready)
                sb.check_dab(sdsdr_result_t'({dab.dab_x, dab.dab_y, dab.dab_pressure,
                                              dab.dirty_x, dab.dirty_y, dab.dirty_w,
                                              dab.dirty_h, dab.pending_count,
                                              dab.last}));
            if (hold_long)
            begin
                hold_long = 0;
                hold = 400;
            end
            else if (hold == 0)
                hold = gap_len();
            if (hold > 0)
            begin
                dab.ready <= 1'b0;
                hold--;
            end
            else
                dab.ready <= 1'b1;
        end
    end

    task automatic send(logic [2:0] op, logic [23:0] x, logic [23:0] y, logic [17:0] p);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid    <= 1'b1;
        smp.op       <= op;
        smp.pos_x    <= x;
        smp.pos_y    <= y;
        smp.pressure <= p;
        do
            @(posedge clk);
        while (!(smp.valid && smp.ready));
        sb.note_sample(op, x, y, p);
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (sb.dab_q.size() != 0)
            @(posedge clk);
        // a short move still runs the root without giving a word
        repeat (80) @(posedge clk);
    endtask

    task automatic write_radius(logic [19:0] r);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RADIUS;
        pwdata  <= {12'd0, r};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_radius(r);
    endtask

    function logic [17:0] rand_pressure();
        if ($urandom_range(0, 9) < 3)
            return 18'($urandom());
        return 18'($urandom_range(0, 65536));
    endfunction

    task automatic random_phase(logic [19:0] r, int items);
        longint span;
        longint dx, dy;
        int     pick;
        write_radius(r);
        span = ((r > 1024) ? longint'(r) : 1024) * 3 / 4;
        send(OP_BEGIN, 24'($urandom()), 24'($urandom()), rand_pressure());
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                dx    = longint'($urandom_range(0, 2 * span)) - span;
                dy    = longint'($urandom_range(0, 2 * span)) - span;
                cur_x = cur_x + dx;
                cur_y = cur_y + dy;
                send(OP_SAMPLE, cur_x[23:0], cur_y[23:0], rand_pressure());
            end
            else if (pick < 85)
            begin
                cur_x = longint'($signed(24'($urandom())));
                cur_y = longint'($signed(24'($urandom())));
                send(OP_SAMPLE, cur_x[23:0], cur_y[23:0], rand_pressure());
            end
            else if (pick < 89)
                send(OP_BEGIN, 24'($urandom()), 24'($urandom()), rand_pressure());
            else if (pick < 92)
                send(OP_END, 24'($urandom()), 24'($urandom()), rand_pressure());
            else if (pick < 95)
                send(OP_CLEAR, 24'($urandom()), 24'($urandom()), rand_pressure());
            else if (pick < 97)
                send(OP_RESET, 24'($urandom()), 24'($urandom()), rand_pressure());
            else
                send(3'($urandom_range(5, 7)), 24'($urandom()), 24'($urandom()),
                     rand_pressure());
        end
    endtask

    initial
    begin
        sb           = new();
        cycles       = 0;
        no_idle      = 0;
        hold_long    = 0;
        cur_x        = 0;
        cur_y        = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        smp.valid    = 1'b0;
        smp.op       = OP_SAMPLE;
        smp.pos_x    = '0;
        smp.pos_y    = '0;
        smp.pressure = '0;
        dab.ready    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset radius, extremes, every op
        send(OP_SAMPLE, 24'd100, 24'd100, 18'd100);
        send(OP_BEGIN, 24'd0, 24'd0, 18'd0);
        send(OP_SAMPLE, 24'd0, 24'd0, 18'h20000);
        send(OP_SAMPLE, 24'd10, 24'd0, 18'd5);
        send(OP_SAMPLE, 24'd4096, 24'd0, 18'h1ffff);
        send(OP_SAMPLE, 24'd6000, 24'd3000, 18'd65536);
        send(OP_SAMPLE, 24'h7fffff, 24'h7fffff, 18'd65537);
        send(OP_SAMPLE, 24'h000100, 24'h7fffff, 18'd1);
        send(OP_CLEAR, 24'd0, 24'd0, 18'd0);
        send(OP_SAMPLE, 24'h800000, 24'h800000, 18'h3ffff);
        send(OP_SAMPLE, 24'h800400, 24'h800000, 18'd32768);
        send(OP_END, 24'd0, 24'd0, 18'd0);
        send(OP_SAMPLE, 24'd500, 24'd500, 18'd500);
        send(3'd5, 24'hffffff, 24'hffffff, 18'h3ffff);
        send(3'd6, 24'd0, 24'd0, 18'd0);
        send(3'd7, 24'h555555, 24'haaaaaa, 18'h15555);
        send(OP_BEGIN, 24'd0, 24'd0, 18'd0);
        send(OP_SAMPLE, 24'hfff000, 24'h001000, 18'd40000);
        send(OP_SAMPLE, 24'h001000, 24'hfff000, 18'd40000);
        send(OP_RESET, 24'd0, 24'd0, 18'd0);
        send(OP_SAMPLE, 24'd700, 24'd700, 18'd700);

        write_radius(20'd0);
        send(OP_BEGIN, 24'd0, 24'd0, 18'd0);
        send(OP_SAMPLE, 24'h000200, 24'h000200, 18'd1000);
        send(OP_SAMPLE, 24'h7fffff, 24'h800000, 18'd1000);
        send(OP_SAMPLE, 24'h000300, 24'h000300, 18'd1000);

        random_phase(20'd4096, 25);
        hold_long = 1;
        random_phase(20'd0, 25);
        no_idle = 1;
        random_phase(20'hfffff, 15);
        no_idle = 0;
        random_phase(20'($urandom_range(1, 8000)), 25);
        random_phase(20'd1024, 20);
        wait_drained();
        random_phase(20'($urandom()), 20);

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.dab_q.size() == 0)
            $display("** stroke_dab_spacer_dirty_rect: PASSED **");
        else
            $display("** stroke_dab_spacer_dirty_rect: FAILED **");
        $finish;
    end
endmodule
